// ----- design/rrwp_pkg.sv -----
// rrwp_pkg: shared constants for the round robin wait pass block
// no dependencies; imported by the interfaces and the core
package rrwp_pkg;

    localparam int NUM_JOBS    = 8;
    localparam int BURST_WIDTH = 16;

    localparam int SLOT_W    = 3;
    localparam int BURST_W   = 16;
    localparam int QUANTUM_W = 16;
    localparam int WAIT_W    = 22;
    localparam int LEFT_W    = 4;

    localparam int IDX_W  = (NUM_JOBS > 1) ? $clog2(NUM_JOBS) : 1;
    localparam int CNT_W  = $clog2(NUM_JOBS + 1);
    localparam int CMP_W  = (BURST_WIDTH > QUANTUM_W) ? BURST_WIDTH : QUANTUM_W;
    localparam int PROD_W = BURST_WIDTH + CNT_W;
    localparam int SUM_W  = ((WAIT_W > PROD_W) ? WAIT_W : PROD_W) + 1;

    localparam logic [WAIT_W-1:0] WAIT_MAX = {WAIT_W{1'b1}};
    localparam logic [LEFT_W-1:0] LEFT_MAX = {LEFT_W{1'b1}};

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_PASS = 1'b1;

endpackage

// ----- design/rrwp_if.sv -----
// rrwp_in_if / rrwp_out_if: valid-ready channels for input and result beats
// depends on rrwp_pkg for field widths
interface rrwp_in_if
    import rrwp_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic                 mode;
    logic [SLOT_W-1:0]    slot;
    logic [BURST_W-1:0]   burst;
    logic [QUANTUM_W-1:0] quantum;

    modport source (output valid, mode, slot, burst, quantum, input ready);
    modport sink   (input valid, mode, slot, burst, quantum, output ready);
endinterface

interface rrwp_out_if
    import rrwp_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [WAIT_W-1:0] wait_time;
    logic [LEFT_W-1:0] jobs_left;
    logic              finished;

    modport source (output valid, wait_time, jobs_left, finished, input ready);
    modport sink   (input valid, wait_time, jobs_left, finished, output ready);
endinterface

// ----- design/rrwp_ram.sv -----
// rrwp_ram: generic simple dual port ram, one write and one registered read port
// no dependencies
module rrwp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ----- design/round_robin_wait_pass_core.sv -----
// round_robin_wait_pass_core: burst table in a ram, load and quantum pass items
// load beat goes S_LOAD then S_FIN; pass beat goes S_PASS once per slot, then S_ACC and S_FIN
// one beat at a time: the input is ready only in S_IDLE, so a new beat waits for the last result;
// a result held in the output register stalls the input until it is taken
// reset: i_rst_n synchronous active low clears the slot valid bits, so every slot reads zero
// depends on rrwp_pkg, rrwp_in_if, rrwp_out_if, rrwp_ram
module round_robin_wait_pass_core
    import rrwp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    rrwp_in_if.sink     i_in,
    rrwp_out_if.source  o_out
);
    typedef enum logic [2:0] {S_IDLE, S_LOAD, S_PASS, S_ACC, S_FIN} t_state;

    t_state                 r_state, n_state;
    logic [NUM_JOBS-1:0]    r_vld, n_vld;
    logic [CNT_W-1:0]       r_live, n_live;
    logic [CNT_W-1:0]       r_before, n_before;
    logic [CNT_W-1:0]       r_done, n_done;
    logic [IDX_W-1:0]       r_idx, n_idx;
    logic                   r_mode, n_mode;
    logic                   r_slot_ok, n_slot_ok;
    logic [BURST_WIDTH-1:0] r_burst, n_burst;
    logic [QUANTUM_W-1:0]   r_quantum, n_quantum;
    logic [PROD_W-1:0]      r_term, n_term;
    logic [WAIT_W-1:0]      r_acc, n_acc;
    logic                   r_rd_vld;
    logic                   r_o_valid, n_o_valid;
    logic [WAIT_W-1:0]      r_o_wait, n_o_wait;
    logic [LEFT_W-1:0]      r_o_left, n_o_left;
    logic                   r_o_fin, n_o_fin;

    logic                   in_ready;
    logic                   in_fire;
    logic                   ram_we;
    logic [IDX_W-1:0]       ram_waddr;
    logic [BURST_WIDTH-1:0] ram_wdata;
    logic [IDX_W-1:0]       ram_raddr;
    logic [BURST_WIDTH-1:0] ram_rdata;

    logic [BURST_WIDTH-1:0] rd_b;
    logic                   rd_live;
    logic                   fits;
    logic [BURST_WIDTH-1:0] base;
    logic [CNT_W-1:0]       later;
    logic [SUM_W-1:0]       sum;
    logic [WAIT_W-1:0]      acc_sat;
    logic [IDX_W-1:0]       slot_idx;

    rrwp_ram #(
        .WIDTH (BURST_WIDTH),
        .DEPTH (NUM_JOBS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign in_ready      = (r_state == S_IDLE);
    assign in_fire       = i_in.valid && in_ready;
    assign i_in.ready    = in_ready;
    assign o_out.valid     = r_o_valid;
    assign o_out.wait_time = r_o_wait;
    assign o_out.jobs_left = r_o_left;
    assign o_out.finished  = r_o_fin;

    assign slot_idx = IDX_W'(i_in.slot);
    assign rd_b     = r_rd_vld ? ram_rdata : '0;
    assign rd_live  = (rd_b != '0);
    assign fits     = (CMP_W'(rd_b) <= CMP_W'(r_quantum));
    assign base     = fits ? rd_b : BURST_WIDTH'(r_quantum);
    assign later    = r_before - r_done - CNT_W'(1);
    assign sum      = SUM_W'(r_acc) + SUM_W'(r_term);
    assign acc_sat  = (sum > SUM_W'(WAIT_MAX)) ? WAIT_MAX : WAIT_W'(sum);

    always_comb begin
        n_state   = r_state;
        n_vld     = r_vld;
        n_live    = r_live;
        n_before  = r_before;
        n_done    = r_done;
        n_idx     = r_idx;
        n_mode    = r_mode;
        n_slot_ok = r_slot_ok;
        n_burst   = r_burst;
        n_quantum = r_quantum;
        n_term    = r_term;
        n_acc     = r_acc;
        n_o_valid = r_o_valid;
        n_o_wait  = r_o_wait;
        n_o_left  = r_o_left;
        n_o_fin   = r_o_fin;
        ram_we    = 1'b0;
        ram_waddr = r_idx;
        ram_wdata = '0;
        ram_raddr = r_idx + IDX_W'(1);

        if (r_o_valid && o_out.ready) begin
            n_o_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                ram_raddr = slot_idx;
                if (in_fire) begin
                    n_mode    = i_in.mode;
                    n_slot_ok = (32'(i_in.slot) < NUM_JOBS);
                    n_burst   = BURST_WIDTH'(i_in.burst);
                    n_quantum = i_in.quantum;
                    n_idx     = slot_idx;
                    n_before  = r_live;
                    n_done    = '0;
                    n_term    = '0;
                    n_acc     = '0;
                    if (i_in.mode == MODE_PASS) begin
                        ram_raddr = '0;
                        n_idx     = '0;
                        n_state   = S_PASS;
                    end else begin
                        n_state = S_LOAD;
                    end
                end
            end
            S_LOAD: begin
                if (r_slot_ok) begin
                    ram_we       = 1'b1;
                    ram_wdata    = r_burst;
                    n_vld[r_idx] = 1'b1;
                    n_live       = r_live + CNT_W'(r_burst != '0) - CNT_W'(rd_live);
                end
                n_state = S_FIN;
            end
            S_PASS: begin
                n_acc  = acc_sat;
                n_term = '0;
                if (rd_live) begin
                    ram_we    = 1'b1;
                    ram_wdata = fits ? '0 : BURST_WIDTH'(CMP_W'(rd_b) - CMP_W'(r_quantum));
                    n_term    = PROD_W'(base) * PROD_W'(later);
                    if (fits) begin
                        n_done = r_done + CNT_W'(1);
                    end
                end
                n_idx = r_idx + IDX_W'(1);
                if (r_idx == IDX_W'(NUM_JOBS - 1)) begin
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                n_acc   = acc_sat;
                n_live  = r_before - r_done;
                n_state = S_FIN;
            end
            S_FIN: begin
                if (!r_o_valid || o_out.ready) begin
                    n_o_valid = 1'b1;
                    n_o_wait  = (r_mode == MODE_PASS) ? r_acc : '0;
                    n_o_left  = (32'(r_live) > 32'(LEFT_MAX)) ? LEFT_MAX : LEFT_W'(r_live);
                    n_o_fin   = (r_live <= CNT_W'(1));
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_vld     <= '0;
            r_live    <= '0;
            r_before  <= '0;
            r_done    <= '0;
            r_idx     <= '0;
            r_mode    <= MODE_LOAD;
            r_slot_ok <= 1'b0;
            r_burst   <= '0;
            r_quantum <= '0;
            r_term    <= '0;
            r_acc     <= '0;
            r_rd_vld  <= 1'b0;
            r_o_valid <= 1'b0;
            r_o_wait  <= '0;
            r_o_left  <= '0;
            r_o_fin   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_vld     <= n_vld;
            r_live    <= n_live;
            r_before  <= n_before;
            r_done    <= n_done;
            r_idx     <= n_idx;
            r_mode    <= n_mode;
            r_slot_ok <= n_slot_ok;
            r_burst   <= n_burst;
            r_quantum <= n_quantum;
            r_term    <= n_term;
            r_acc     <= n_acc;
            r_rd_vld  <= r_vld[ram_raddr];
            r_o_valid <= n_o_valid;
            r_o_wait  <= n_o_wait;
            r_o_left  <= n_o_left;
            r_o_fin   <= n_o_fin;
        end
    end

`ifndef SYNTHESIS
    a_live_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_live) <= NUM_JOBS)
        else $error("live count beyond table depth");

    a_done_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ACC) |-> (r_done <= r_before))
        else $error("more jobs finished than were live");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("beat accepted while busy");

    a_load_no_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && r_mode == MODE_LOAD && (!r_o_valid || o_out.ready))
        |=> (r_o_valid && r_o_wait == '0))
        else $error("load result carries wait time");
`endif

endmodule

// ----- verif/round_robin_wait_pass_core_tb.sv -----
// round_robin_wait_pass_core_tb: self-checking bench for the quantum pass scheduler core
// predicts each result beat from a local copy of the burst table and checks it field by field
// depends on rrwp_pkg, rrwp_in_if, rrwp_out_if and round_robin_wait_pass_core
module round_robin_wait_pass_core_tb
    import rrwp_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 4 * (NUM_JOBS + 3);

    typedef struct packed {
        logic [WAIT_W-1:0] wait_time;
        logic [LEFT_W-1:0] jobs_left;
        logic              finished;
    } t_pass_result;

    logic i_clk;
    logic i_rst_n;

    rrwp_in_if  in_ch();
    rrwp_out_if out_ch();

    round_robin_wait_pass_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    logic [BURST_W-1:0] burst_tbl [NUM_JOBS];
    t_pass_result       expected_results [$];
    int                 error_count;
    int                 items_sent;
    int                 stalled_cycles;
    int                 rx_hold_req;
    bit                 idle_on;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic int unsigned live_jobs();
        int unsigned n;
        n = 0;
        foreach (burst_tbl[k]) begin
            if (burst_tbl[k] != '0) n++;
        end
        return n;
    endfunction

    function automatic logic [BURST_W-1:0] largest_burst();
        logic [BURST_W-1:0] top;
        top = '0;
        foreach (burst_tbl[k]) begin
            if (burst_tbl[k] > top) top = burst_tbl[k];
        end
        return top;
    endfunction

    // applies one beat to the local table and returns the result it should produce
    function automatic t_pass_result schedule_step(input logic mode,
                                                   input logic [SLOT_W-1:0] slot,
                                                   input logic [BURST_W-1:0] burst,
                                                   input logic [QUANTUM_W-1:0] quantum);
        t_pass_result      res;
        longint unsigned   acc;
        int unsigned       live_start;
        int unsigned       done_jobs;
        int unsigned       later;
        int unsigned       left;
        acc = 0;
        if (mode == MODE_LOAD) begin
            if (slot < NUM_JOBS) burst_tbl[slot] = burst;
        end else begin
            live_start = live_jobs();
            done_jobs  = 0;
            for (int k = 0; k < NUM_JOBS; k++) begin
                if (burst_tbl[k] != '0) begin
                    later = live_start - done_jobs - 1;
                    if (burst_tbl[k] <= quantum) begin
                        acc += burst_tbl[k] * later;
                        burst_tbl[k] = '0;
                        done_jobs++;
                    end else begin
                        acc += quantum * later;
                        burst_tbl[k] = burst_tbl[k] - quantum;
                    end
                end
            end
            if (acc > WAIT_MAX) acc = WAIT_MAX;
        end
        left          = live_jobs();
        res.wait_time = acc[WAIT_W-1:0];
        res.jobs_left = (left > LEFT_MAX) ? LEFT_MAX : LEFT_W'(left);
        res.finished  = (left <= 1);
        return res;
    endfunction

    function automatic logic [BURST_W-1:0] rand_magnitude();
        int          bits;
        logic [31:0] raw;
        bits = $urandom_range(0, BURST_W);
        raw  = $urandom;
        return BURST_W'(raw >> (32 - bits));
    endfunction

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= 50) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task automatic send_item(input logic mode, input logic [SLOT_W-1:0] slot,
                             input logic [BURST_W-1:0] burst,
                             input logic [QUANTUM_W-1:0] quantum);
        int gap;
        gap = idle_on ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.mode    <= mode;
        in_ch.slot    <= slot;
        in_ch.burst   <= burst;
        in_ch.quantum <= quantum;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        expected_results.push_back(schedule_step(mode, slot, burst, quantum));
        items_sent++;
    endtask

    task automatic load_slot(input logic [SLOT_W-1:0] slot, input logic [BURST_W-1:0] burst);
        send_item(MODE_LOAD, slot, burst, QUANTUM_W'($urandom));
    endtask

    task automatic run_pass(input logic [QUANTUM_W-1:0] quantum);
        send_item(MODE_PASS, SLOT_W'($urandom), BURST_W'($urandom), quantum);
    endtask

    task automatic wait_for_results();
        in_ch.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed();
        run_pass(16'd1);
        load_slot(3'd0, 16'hFFFF);
        load_slot(3'd7, 16'd1);
        load_slot(3'd3, 16'd0);
        run_pass(16'hFFFF);
        load_slot(3'd0, 16'd1);
        load_slot(3'd1, 16'd2);
        load_slot(3'd2, 16'hFFFF);
        load_slot(3'd3, 16'h8000);
        load_slot(3'd4, 16'h7FFF);
        load_slot(3'd5, 16'd3);
        load_slot(3'd6, 16'h5555);
        load_slot(3'd7, 16'hAAAA);
        // zero quantum leaves every job untouched
        run_pass(16'd0);
        run_pass(16'd1);
        run_pass(16'h8000);
        load_slot(3'd2, 16'd0);
        run_pass(16'hFFFF);
        run_pass(16'hFFFF);
        wait_for_results();
    endtask

    task automatic test_random_schedules(input int n_items);
        int                   target;
        int                   n_loads;
        int                   passes;
        logic [QUANTUM_W-1:0] q;
        target = items_sent + n_items;
        while (items_sent < target) begin
            n_loads = $urandom_range(1, NUM_JOBS + 2);
            repeat (n_loads) begin
                load_slot(SLOT_W'($urandom_range(0, NUM_JOBS - 1)), rand_magnitude());
            end
            passes = 0;
            while (live_jobs() > 1 && passes < 16) begin
                if ($urandom_range(0, 7) == 0) begin
                    load_slot(SLOT_W'($urandom_range(0, NUM_JOBS - 1)), rand_magnitude());
                end
                q = largest_burst() >> $urandom_range(0, 4);
                if ($urandom_range(0, 7) == 0) q = rand_magnitude();
                run_pass(q);
                passes++;
            end
            if ($urandom_range(0, 1) == 1) run_pass(rand_magnitude());
        end
        wait_for_results();
    endtask

    task automatic test_random_noise(input int n_items);
        repeat (n_items) begin
            send_item(1'($urandom_range(0, 1)), SLOT_W'($urandom), BURST_W'($urandom),
                      QUANTUM_W'($urandom));
        end
        wait_for_results();
    endtask

    // receiver stalls long enough for a result to back up into the input
    task automatic test_backpressure();
        rx_hold_req = HOLD_CYCLES;
        test_random_schedules(40);
    endtask

    task automatic test_back_to_back(input int n_items);
        idle_on = 1'b0;
        test_random_schedules(n_items);
        idle_on = 1'b1;
    endtask

    initial begin
        int stall;
        out_ch.ready <= 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (rx_hold_req > 0) begin
                out_ch.ready <= 1'b0;
                repeat (rx_hold_req) @(posedge i_clk);
                rx_hold_req = 0;
            end
            stall = idle_on ? $urandom_range(0, 4) : 0;
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (out_ch.valid !== 1'b1);
        end
    end

    always @(posedge i_clk) begin
        t_pass_result want;
        if (i_rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result beat with no item outstanding");
            end else begin
                want = expected_results.pop_front();
                if (out_ch.wait_time !== want.wait_time) begin
                    report_mismatch($sformatf("wait_time got %0d want %0d",
                                              out_ch.wait_time, want.wait_time));
                end
                if (out_ch.jobs_left !== want.jobs_left) begin
                    report_mismatch($sformatf("jobs_left got %0d want %0d",
                                              out_ch.jobs_left, want.jobs_left));
                end
                if (out_ch.finished !== want.finished) begin
                    report_mismatch($sformatf("finished got %0b want %0b",
                                              out_ch.finished, want.finished));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n !== 1'b1 || (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
            (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
            stalled_cycles = 0;
        end else begin
            stalled_cycles++;
            if (stalled_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial begin
        error_count    = 0;
        items_sent     = 0;
        stalled_cycles = 0;
        rx_hold_req    = 0;
        idle_on        = 1'b1;
        foreach (burst_tbl[k]) burst_tbl[k] = '0;
        i_rst_n       <= 1'b0;
        in_ch.valid   <= 1'b0;
        in_ch.mode    <= MODE_LOAD;
        in_ch.slot    <= '0;
        in_ch.burst   <= '0;
        in_ch.quantum <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_schedules(1100);
        test_backpressure();
        test_back_to_back(150);
        test_random_noise(200);

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
        end
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ----- round_robin_wait_pass_core.f -----
design/rrwp_pkg.sv
design/rrwp_if.sv
design/rrwp_ram.sv
design/round_robin_wait_pass_core.sv
verif/round_robin_wait_pass_core_tb.sv
